[src/sfr_pkg.sv]
// Shared types and constants for the stream find-and-replace block.
// Used by sfr_match and stream_find_and_replace_core; depends on nothing.
`default_nettype none

package sfr_pkg;

  // Longest pattern the matcher compares against.
  localparam int MAX_PATTERN = 8;
  // Depth of the pending buffer and of the output run buffer.
  localparam int BUF_DEPTH   = 8;
  // Width of a count that can hold BUF_DEPTH itself.
  localparam int CNT_W       = $clog2(BUF_DEPTH + 1);
  localparam int TALLY_W     = 16;

  typedef logic [BUF_DEPTH-1:0][7:0] buf_t;

  typedef enum logic [1:0] {
    REG_PATTERN_BYTES,
    REG_PATTERN_LENGTH,
    REG_REPLACEMENT_BYTES,
    REG_REPLACEMENT_LENGTH
  } cfg_reg_t;

  // Everything one input character causes: the run of output characters,
  // the optional done result, and the state left for the next character.
  typedef struct packed {
    buf_t               chars;
    logic [CNT_W-1:0]   char_cnt;
    logic               done;
    logic [TALLY_W-1:0] total;
    buf_t               next_pend;
    logic [CNT_W-1:0]   next_cnt;
    logic [TALLY_W-1:0] next_tally;
  } emit_t;

endpackage

`default_nettype wire

[src/stream_find_and_replace_core.sv]
// Top level of the stream find-and-replace block: input slot, pending
// buffer, output run buffer and configuration registers. Uses sfr_pkg, sfr_match.
//
//   Channel | Handshake             | Payload
//   --------+-----------------------+--------------------------------------------
//   input   | in_valid / in_ready   | text_char, end_of_text
//   output  | out_valid / out_ready | out_char, char_valid, done_res,
//           |                       | replace_total, last_of_run
//   config  | cfg_valid / cfg_ready | cfg_index, cfg_data (cfg_ready is always 1)
//
// Items that yield at most one result stream at one per cycle while out_ready
// is high. An item that yields m results holds the output run buffer until all
// m transfer (m is at most nine: eight characters and the done result), and the
// next item waits in the input slot until the last of them transfers.
// An accepted character is registered in the input slot, its results in the run
// buffer. Reset (synchronous, active high) empties both buffers, clears the
// counts and zeroes all configuration registers. Output stalls only back up
// into the input slot; an item producing no result leaves the run buffer empty.
`default_nettype none

module stream_find_and_replace_core (
  input  logic                         clk,
  input  logic                         rst,
  // Input text channel.
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [7:0]                   text_char,
  input  logic                         end_of_text,
  // Output result channel.
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [7:0]                   out_char,
  output logic                         char_valid,
  output logic                         done_res,
  output logic [sfr_pkg::TALLY_W-1:0]  replace_total,
  output logic                         last_of_run,
  // Configuration write channel.
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [1:0]                   cfg_index,
  input  logic [63:0]                  cfg_data
);
  import sfr_pkg::*;

  // Configuration registers.
  logic [63:0]        pattern_bytes;
  logic [3:0]         pattern_length;
  logic [63:0]        replacement_bytes;
  logic [3:0]         replacement_length;

  // Input slot: holds one accepted character until the run buffer frees up.
  logic               in_full;
  logic [7:0]         in_char;
  logic               in_last;

  // Pending buffer: always a proper prefix of the pattern.
  buf_t               pending_chars;
  logic [CNT_W-1:0]   pending_count;
  logic [TALLY_W-1:0] match_tally;

  // Output run buffer: characters shift toward slot 0, done result last.
  buf_t               run_chars;
  logic [CNT_W-1:0]   run_cnt;
  logic               run_done;
  logic [TALLY_W-1:0] run_total;

  emit_t              emit;
  logic               out_take;
  logic               run_free;
  logic               process;

  sfr_match u_match (
    .text_char          (in_char),
    .end_of_text        (in_last),
    .pend               (pending_chars),
    .pend_cnt           (pending_count),
    .tally              (match_tally),
    .pattern_bytes      (pattern_bytes),
    .pattern_length     (pattern_length),
    .replacement_bytes  (replacement_bytes),
    .replacement_length (replacement_length),
    .emit               (emit)
  );

  // The head of the run is a character while any remain, then the done result.
  assign out_valid     = (run_cnt != '0) || run_done;
  assign char_valid    = (run_cnt != '0);
  assign done_res      = (run_cnt == '0) && run_done;
  assign out_char      = char_valid ? run_chars[0] : 8'd0;
  assign replace_total = done_res ? run_total : '0;
  assign last_of_run   = ((run_cnt == CNT_W'(1)) && !run_done) || done_res;

  assign out_take = out_valid && out_ready;
  // The run buffer can take a new item when empty or when its last result
  // transfers in this cycle.
  assign run_free = !out_valid || (out_take && last_of_run);
  assign process  = in_full && run_free;
  assign in_ready = !in_full || process;
  assign cfg_ready = 1'b1;

  // Input slot.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (process) begin
      in_full <= 1'b0;
    end
    if (in_valid && in_ready) begin
      in_char <= text_char;
      in_last <= end_of_text;
    end
  end

  // Configuration registers. A pattern write throws away pending characters.
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes      <= '0;
      pattern_length     <= '0;
      replacement_bytes  <= '0;
      replacement_length <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_PATTERN_BYTES:      pattern_bytes      <= cfg_data;
        REG_PATTERN_LENGTH:     pattern_length     <= cfg_data[3:0];
        REG_REPLACEMENT_BYTES:  replacement_bytes  <= cfg_data;
        REG_REPLACEMENT_LENGTH: replacement_length <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Pending buffer and replacement tally.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_count <= '0;
      match_tally   <= '0;
    end else if (cfg_valid && cfg_ready &&
                 ((cfg_reg_t'(cfg_index) == REG_PATTERN_BYTES) ||
                  (cfg_reg_t'(cfg_index) == REG_PATTERN_LENGTH))) begin
      pending_count <= '0;
    end else if (process) begin
      pending_count <= emit.next_cnt;
      match_tally   <= emit.next_tally;
    end
    if (process) begin
      pending_chars <= emit.next_pend;
    end
  end

  // Output run buffer.
  always_ff @(posedge clk) begin
    if (rst) begin
      run_cnt  <= '0;
      run_done <= 1'b0;
    end else if (process) begin
      run_cnt  <= emit.char_cnt;
      run_done <= emit.done;
    end else if (out_take) begin
      if (run_cnt != '0) begin
        run_cnt <= run_cnt - CNT_W'(1);
      end else begin
        run_done <= 1'b0;
      end
    end
    if (process) begin
      run_chars <= emit.chars;
      run_total <= emit.total;
    end else if (out_take && (run_cnt != '0)) begin
      for (int i = 0; i < BUF_DEPTH - 1; i++) begin
        run_chars[i] <= run_chars[i+1];
      end
    end
  end

`ifndef SYNTH
  a_run_cnt_range: assert property (@(posedge clk) disable iff (rst)
    run_cnt <= CNT_W'(BUF_DEPTH))
    else $error("run buffer count out of range");

  a_pending_proper: assert property (@(posedge clk) disable iff (rst)
    pending_count < CNT_W'(MAX_PATTERN))
    else $error("pending buffer holds a full pattern");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    (process && in_last) |=> (pending_count == '0) && (match_tally == '0))
    else $error("end of text did not clear pending state");

  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    done_res |-> last_of_run && !char_valid)
    else $error("done result not marked last");
`endif

endmodule

`default_nettype wire

[src/sfr_match.sv]
// Combinational matcher: appends one character to the pending buffer and
// works out the output run and the next pending state. Depends on sfr_pkg.
`default_nettype none

module sfr_match (
  input  logic [7:0]                 text_char,
  input  logic                       end_of_text,
  input  sfr_pkg::buf_t              pend,
  input  logic [sfr_pkg::CNT_W-1:0]  pend_cnt,
  input  logic [sfr_pkg::TALLY_W-1:0] tally,
  input  logic [63:0]                pattern_bytes,
  input  logic [3:0]                 pattern_length,
  input  logic [63:0]                replacement_bytes,
  input  logic [3:0]                 replacement_length,
  output sfr_pkg::emit_t             emit
);
  import sfr_pkg::*;

  buf_t                 buff;
  logic [CNT_W-1:0]     plen;
  logic [CNT_W-1:0]     rlen;
  logic [CNT_W-1:0]     n;
  logic [CNT_W-1:0]     k;
  logic [BUF_DEPTH:0][BUF_DEPTH-1:0] cmp;
  logic [BUF_DEPTH:0]   ok;
  logic                 full_match;
  logic [TALLY_W-1:0]   tally_upd;

  always_comb begin
    plen = (pattern_length > CNT_W'(MAX_PATTERN)) ? CNT_W'(MAX_PATTERN)
                                                  : CNT_W'(pattern_length);
    rlen = (replacement_length > CNT_W'(BUF_DEPTH)) ? CNT_W'(BUF_DEPTH)
                                                    : CNT_W'(replacement_length);
    n = pend_cnt + CNT_W'(1);

    // Pending characters with the new one appended; slots past it are unused.
    for (int i = 0; i < BUF_DEPTH; i++) begin
      buff[i] = (CNT_W'(i) < pend_cnt) ? pend[i] : text_char;
    end

    // cmp[s][j]: the character at s + j equals pattern byte j.
    for (int s = 0; s <= BUF_DEPTH; s++) begin
      for (int j = 0; j < BUF_DEPTH; j++) begin
        cmp[s][j] = (s + j < BUF_DEPTH) &&
                    (buff[$clog2(BUF_DEPTH)'(s + j)] == pattern_bytes[8*j +: 8]);
      end
    end

    // ok[s]: dropping s oldest characters leaves a proper pattern prefix.
    for (int s = 0; s <= BUF_DEPTH; s++) begin
      ok[s] = (CNT_W'(s) <= n) && ((n - CNT_W'(s)) < plen);
      for (int j = 0; j < BUF_DEPTH; j++) begin
        if (CNT_W'(j) < n - CNT_W'(s)) begin
          ok[s] = ok[s] & cmp[s][j];
        end
      end
    end

    full_match = (n == plen);
    for (int j = 0; j < BUF_DEPTH; j++) begin
      if (CNT_W'(j) < n) begin
        full_match = full_match & cmp[0][j];
      end
    end

    // Smallest shift wins; shifting everything out always qualifies.
    k = n;
    for (int s = BUF_DEPTH; s >= 0; s--) begin
      if (ok[s]) begin
        k = CNT_W'(s);
      end
    end

    tally_upd = (full_match && (plen != '0) && (tally != {TALLY_W{1'b1}}))
              ? tally + TALLY_W'(1) : tally;

    emit.chars    = buff;
    emit.char_cnt = end_of_text ? n : k;
    for (int i = 0; i < BUF_DEPTH; i++) begin
      emit.next_pend[i] = buff[$clog2(BUF_DEPTH)'(CNT_W'(i) + k)];
    end
    emit.next_cnt = end_of_text ? '0 : (n - k);

    if (plen == '0) begin
      emit.chars[0]  = text_char;
      emit.char_cnt  = CNT_W'(1);
      emit.next_pend = pend;
      emit.next_cnt  = '0;
    end else if (full_match) begin
      emit.chars    = replacement_bytes;
      emit.char_cnt = rlen;
      emit.next_cnt = '0;
    end

    emit.done       = end_of_text;
    emit.total      = tally_upd;
    emit.next_tally = end_of_text ? '0 : tally_upd;
  end

endmodule

`default_nettype wire
